FILE: rtl/htdp_pkg.sv
// Shared types and constants for the depth-preferred hash table.
// Used by htdp_ctrl, htdp_datapath and hash_table_depth_preferred.
`default_nettype none

package htdp_pkg;

    localparam int unsigned ENTRIES = 4096;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] AGE_RESET = 8'd1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] score;
        logic [15:0] eval;
        logic [7:0]  depth;
        logic [1:0]  bound;
        logic [15:0] move;
        logic [7:0]  age;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic sweep;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic op_clear;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/htdp_ctrl.sv
// Controller state machine for the depth-preferred hash table.
// Depends on htdp_pkg; drives commands to htdp_datapath.
`default_nettype none

module htdp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire htdp_pkg::status_t status,
    output htdp_pkg::cmd_t         cmd
);
    import htdp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = status.op_clear ? S_CLEAR : S_FIN;
            end
            S_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.read    = (state_reg == S_READ);
        cmd.sweep   = (state_reg == S_INIT) || (state_reg == S_CLEAR);
        cmd.finish  = (state_reg == S_FIN) && status.out_free;
    end

`ifndef NO_ASSERTIONS
    a_capture_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_READ)
        else $error("capture not followed by read");
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && status.sweep_last |=> state_reg == S_FIN)
        else $error("clear sweep did not finish");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE && !in_stall)
        else $error("finish not followed by idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/htdp_datapath.sv
// Datapath for the depth-preferred hash table: entry memory, replacement
// compare, age and output register. Depends on htdp_pkg; driven by htdp_ctrl.
`default_nettype none

module htdp_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire htdp_pkg::cmd_t    cmd,
    output htdp_pkg::status_t      status,
    input  wire logic [1:0]        opcode,
    input  wire logic [63:0]       pos_key,
    input  wire logic [7:0]        search_depth,
    input  wire logic signed [15:0] search_score,
    input  wire logic signed [15:0] static_eval,
    input  wire logic [1:0]        bound_kind,
    input  wire logic [15:0]       best_move,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   hit,
    output logic                   written,
    output logic [7:0]             found_depth,
    output logic signed [15:0]     found_score,
    output logic signed [15:0]     found_eval,
    output logic [1:0]             found_bound,
    output logic [15:0]            found_move,
    output logic [7:0]             found_age
);
    import htdp_pkg::*;

    entry_t mem [ENTRIES];

    logic [1:0]       op_reg;
    logic [63:0]      key_reg;
    logic [7:0]       depth_reg;
    logic [15:0]      score_reg;
    logic [15:0]      eval_reg;
    logic [1:0]       bound_reg;
    logic [15:0]      move_reg;
    entry_t           rd_reg;

    logic [7:0]       age_reg;
    logic [7:0]       age_next;
    logic [IDX_W-1:0] sweep_cnt_reg;
    logic [IDX_W-1:0] sweep_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             hit_reg;
    logic             written_reg;
    entry_t           found_reg;

    logic [IDX_W-1:0] slot;
    logic             key_match;
    logic             is_store;
    logic             is_probe;
    logic             do_write;
    logic             do_hit;
    entry_t           wr_entry;

    assign slot      = key_reg[IDX_W-1:0];
    assign key_match = (rd_reg.key == key_reg);
    assign is_store  = (op_reg == OP_STORE);
    assign is_probe  = (op_reg == OP_PROBE);
    assign do_write  = is_store && (!key_match || (depth_reg >= rd_reg.depth));
    assign do_hit    = is_probe && key_match;

    always_comb
    begin
        wr_entry.key   = key_reg;
        wr_entry.score = score_reg;
        wr_entry.eval  = eval_reg;
        wr_entry.depth = depth_reg;
        wr_entry.bound = bound_reg;
        wr_entry.move  = move_reg;
        wr_entry.age   = age_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            key_reg   <= pos_key;
            depth_reg <= search_depth;
            score_reg <= search_score;
            eval_reg  <= static_eval;
            bound_reg <= bound_kind;
            move_reg  <= best_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            mem[sweep_cnt_reg] <= '0;
        end
        else if (cmd.finish && do_write)
        begin
            mem[slot] <= wr_entry;
        end
        if (cmd.read)
        begin
            rd_reg <= mem[slot];
        end
    end

    always_comb
    begin
        age_next       = age_reg;
        sweep_cnt_next = sweep_cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.finish && status.op_clear)
        begin
            age_next = age_reg + 8'd1;
        end
        if (cmd.sweep)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end
        priority if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg       <= AGE_RESET;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            age_reg       <= age_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit_reg     <= do_hit;
            written_reg <= do_write;
            found_reg   <= do_hit ? rd_reg : '0;
        end
    end

    assign status.sweep_last = (sweep_cnt_reg == {IDX_W{1'b1}});
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.op_clear   = (op_reg == OP_CLEAR);

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign written     = written_reg;
    assign found_depth = found_reg.depth;
    assign found_score = found_reg.score;
    assign found_eval  = found_reg.eval;
    assign found_bound = found_reg.bound;
    assign found_move  = found_reg.move;
    assign found_age   = found_reg.age;

`ifndef NO_ASSERTIONS
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result loaded over a pending transaction");
    a_hit_or_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && written_reg))
        else $error("result both hit and written");
    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> !cmd.finish && !cmd.read && !cmd.capture)
        else $error("sweep overlaps other memory access");
`endif

endmodule

`default_nettype wire

FILE: rtl/hash_table_depth_preferred.sv
// Top level of the depth-preferred hash table; joins htdp_ctrl and
// htdp_datapath. Depends on htdp_pkg.
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall  | opcode pos_key search_depth search_score
//           |                      | static_eval bound_kind best_move
//   output  | out_valid / out_stall| hit written found_depth found_score
//           |                      | found_eval found_bound found_move found_age
//
// Store and probe each run through accept, memory read, then compare and write.
// Clear adds a sweep with one zero write per entry through the write port.
// After reset a clearing pass over all ENTRIES entries runs with in_stall high.
// The result register holds while out_stall is high; the next transaction is
// accepted meanwhile and waits for it in the compare step.
`default_nettype none

module hash_table_depth_preferred (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         opcode,
    input  wire logic [63:0]        pos_key,
    input  wire logic [7:0]         search_depth,
    input  wire logic signed [15:0] search_score,
    input  wire logic signed [15:0] static_eval,
    input  wire logic [1:0]         bound_kind,
    input  wire logic [15:0]        best_move,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic                    written,
    output logic [7:0]              found_depth,
    output logic signed [15:0]      found_score,
    output logic signed [15:0]      found_eval,
    output logic [1:0]              found_bound,
    output logic [15:0]             found_move,
    output logic [7:0]              found_age
);
    import htdp_pkg::*;

    cmd_t    cmd;
    status_t status;

    htdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    htdp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .pos_key      (pos_key),
        .search_depth (search_depth),
        .search_score (search_score),
        .static_eval  (static_eval),
        .bound_kind   (bound_kind),
        .best_move    (best_move),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .written      (written),
        .found_depth  (found_depth),
        .found_score  (found_score),
        .found_eval   (found_eval),
        .found_bound  (found_bound),
        .found_move   (found_move),
        .found_age    (found_age)
    );

endmodule

`default_nettype wire
